FILE: rtl/core/one_wire_pulse_width_cmd_sender_assert.svh
// Assertion macros for the one-wire command sender.
// Needs no package; included by the top level only.
`ifndef ONE_WIRE_PULSE_WIDTH_CMD_SENDER_ASSERT_SVH
`define ONE_WIRE_PULSE_WIDTH_CMD_SENDER_ASSERT_SVH

// Same-cycle implication, disabled while in reset
`define OWR_ASSERT_IMP(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("owr assertion failed");

// Next-cycle implication, disabled while in reset
`define OWR_ASSERT_NXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("owr assertion failed");

`endif

FILE: rtl/core/owr_pkg.sv
// Shared types and constants for the one-wire command sender.
// No dependencies; imported by owr_cfg_regs, owr_fsm, owr_out_reg, the top level and the testbench.
package owr_pkg;

  localparam int unsigned COUNT_BITS_DEF = 16;
  localparam int unsigned CFG_W          = 16;
  localparam int unsigned APB_AW         = 4;
  localparam int unsigned APB_DW         = 32;

  // Register indexes (byte address is 4 * index)
  localparam logic [1:0] REG_START = 2'd0;
  localparam logic [1:0] REG_LONG  = 2'd1;
  localparam logic [1:0] REG_SHORT = 2'd2;
  localparam logic [1:0] REG_GUARD = 2'd3;

  // Register reset values
  localparam logic [CFG_W-1:0] START_RST = 16'd40;
  localparam logic [CFG_W-1:0] LONG_RST  = 16'd12;
  localparam logic [CFG_W-1:0] SHORT_RST = 16'd4;
  localparam logic [CFG_W-1:0] GUARD_RST = 16'd1000;

  // Command codes
  localparam logic [7:0] VOL_BASE  = 8'hE0;
  localparam logic [7:0] STOP_CODE = 8'hFE;
  localparam logic [7:0] VOL_MAX   = 8'd7;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_RAW  = 2'd1,
    OP_VOL  = 2'd2,
    OP_STOP = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_NONE  = 2'd0,
    ST_OK    = 2'd1,
    ST_BUSY  = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_START = 3'd1,
    PH_HIGH  = 3'd2,
    PH_LOW   = 3'd3,
    PH_GUARD = 3'd4
  } phase_e;

  typedef struct packed {
    logic [CFG_W-1:0] start_low_ticks;
    logic [CFG_W-1:0] long_ticks;
    logic [CFG_W-1:0] short_ticks;
    logic [CFG_W-1:0] guard_ticks;
  } cfg_t;

  typedef struct packed {
    logic    line_level;
    logic    busy_res;
    status_e status;
  } res_t;

endpackage

FILE: rtl/core/owr_ifs.sv
// Valid/ready channel interfaces for command beats and result beats.
// Depends on nothing; used by the top level.
interface owr_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] cmd_byte;
  logic [7:0] volume_level;

  modport source (output valid, opcode, cmd_byte, volume_level, input ready);
  modport sink   (input valid, opcode, cmd_byte, volume_level, output ready);
endinterface

interface owr_res_if;
  logic       valid;
  logic       ready;
  logic       line_level;
  logic       busy_res;
  logic [1:0] status;

  modport source (output valid, line_level, busy_res, status, input ready);
  modport sink   (input valid, line_level, busy_res, status, output ready);
endinterface

FILE: rtl/core/owr_cfg_regs.sv
// APB-style register block holding the four timing registers.
// Depends on owr_pkg.
module owr_cfg_regs
  import owr_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t cfg_q;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign cfg_o  = cfg_q;

  // register write on the access cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_low_ticks <= START_RST;
      cfg_q.long_ticks      <= LONG_RST;
      cfg_q.short_ticks     <= SHORT_RST;
      cfg_q.guard_ticks     <= GUARD_RST;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_START: cfg_q.start_low_ticks <= pwdata[CFG_W-1:0];
        REG_LONG:  cfg_q.long_ticks      <= pwdata[CFG_W-1:0];
        REG_SHORT: cfg_q.short_ticks     <= pwdata[CFG_W-1:0];
        REG_GUARD: cfg_q.guard_ticks     <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (paddr[3:2])
      REG_START: prdata = APB_DW'(cfg_q.start_low_ticks);
      REG_LONG:  prdata = APB_DW'(cfg_q.long_ticks);
      REG_SHORT: prdata = APB_DW'(cfg_q.short_ticks);
      REG_GUARD: prdata = APB_DW'(cfg_q.guard_ticks);
      default:   prdata = '0;
    endcase
  end

endmodule

FILE: rtl/core/owr_fsm.sv
// Line sequencer: phase, bit counter, shift byte and tick counter.
// Depends on owr_pkg; computes the result of each accepted beat.
module owr_fsm
  import owr_pkg::*;
#(
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  op_e        opcode_i,
  input  logic [7:0] cmd_byte_i,
  input  logic [7:0] volume_level_i,
  input  cfg_t       cfg_i,
  output res_t       res_o,
  output logic       busy_o
);

  localparam int unsigned CMP_W = (COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  phase_e                phase_q, phase_d;
  logic [2:0]            bit_idx_q, bit_idx_d;
  logic [7:0]            shift_q, shift_d;
  logic [COUNT_BITS-1:0] tick_q, tick_d;
  logic                  line_q, line_d;

  logic [COUNT_BITS-1:0] tick_inc;
  logic [CFG_W-1:0]      len_raw;
  logic [CFG_W-1:0]      len_eff;
  logic                  done;
  logic [7:0]            req_byte;
  status_e               status;

  assign busy_o = (phase_q != PH_IDLE);

  // saturating tick count and end-of-phase test
  assign tick_inc = (tick_q == CNT_MAX) ? tick_q : tick_q + 1'b1;
  assign len_eff  = (len_raw == '0) ? CFG_W'(1) : len_raw;
  assign done     = (CMP_W'(tick_inc) >= CMP_W'(len_eff)) || (tick_inc == CNT_MAX);

  // length of the current phase
  always_comb begin
    case (phase_q)
      PH_START: len_raw = cfg_i.start_low_ticks;
      PH_HIGH:  len_raw = shift_q[0] ? cfg_i.long_ticks : cfg_i.short_ticks;
      PH_LOW:   len_raw = shift_q[0] ? cfg_i.short_ticks : cfg_i.long_ticks;
      PH_GUARD: len_raw = cfg_i.guard_ticks;
      default:  len_raw = cfg_i.guard_ticks;
    endcase
  end

  // byte loaded by a request
  always_comb begin
    case (opcode_i)
      OP_RAW:  req_byte = cmd_byte_i;
      OP_VOL:  req_byte = VOL_BASE + {5'd0, volume_level_i[2:0]};
      OP_STOP: req_byte = STOP_CODE;
      default: req_byte = cmd_byte_i;
    endcase
  end

  // next state per beat
  always_comb begin
    phase_d   = phase_q;
    bit_idx_d = bit_idx_q;
    shift_d   = shift_q;
    tick_d    = tick_q;
    line_d    = line_q;
    status    = ST_NONE;
    if (accept_i) begin
      if (opcode_i == OP_TICK) begin
        if (phase_q != PH_IDLE) begin
          tick_d = tick_inc;
          if (done) begin
            tick_d = '0;
            case (phase_q)
              PH_START: begin
                phase_d = PH_HIGH;
                line_d  = 1'b1;
              end
              PH_HIGH: begin
                phase_d = PH_LOW;
                line_d  = 1'b0;
              end
              PH_LOW: begin
                line_d = 1'b1;
                if (bit_idx_q == 3'd7) begin
                  bit_idx_d = '0;
                  phase_d   = (cfg_i.guard_ticks == '0) ? PH_IDLE : PH_GUARD;
                end else begin
                  bit_idx_d = bit_idx_q + 3'd1;
                  shift_d   = {1'b0, shift_q[7:1]};
                  phase_d   = PH_HIGH;
                end
              end
              default: phase_d = PH_IDLE;
            endcase
          end
        end
      end else if ((opcode_i == OP_VOL) && (volume_level_i > VOL_MAX)) begin
        status = ST_RANGE;
      end else if (phase_q != PH_IDLE) begin
        status = ST_BUSY;
      end else begin
        status    = ST_OK;
        shift_d   = req_byte;
        bit_idx_d = '0;
        tick_d    = '0;
        line_d    = 1'b0;
        phase_d   = PH_START;
      end
    end
  end

  assign res_o.line_level = line_d;
  assign res_o.busy_res   = (phase_d != PH_IDLE);
  assign res_o.status     = status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      bit_idx_q <= '0;
      shift_q   <= '0;
      tick_q    <= '0;
      line_q    <= 1'b1;
    end else begin
      phase_q   <= phase_d;
      bit_idx_q <= bit_idx_d;
      shift_q   <= shift_d;
      tick_q    <= tick_d;
      line_q    <= line_d;
    end
  end

endmodule

FILE: rtl/core/owr_out_reg.sv
// Result register: holds one result beat until the sink takes it.
// Depends on owr_pkg; drives the input-side ready.
module owr_out_reg
  import owr_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic load_i,
  input  res_t res_i,
  input  logic out_ready_i,
  output logic out_valid_o,
  output res_t res_o,
  output logic in_ready_o
);

  logic valid_q;
  res_t res_q;

  // free when empty or being drained this cycle
  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule

FILE: rtl/core/one_wire_pulse_width_cmd_sender.sv
// Top level of the one-wire command sender: registers, sequencer, result register.
// Depends on owr_pkg, owr_ifs, owr_cfg_regs, owr_fsm, owr_out_reg and the assert header.
//
//   channel | dir | handshake       | payload
//   --------+-----+-----------------+-----------------------------------
//   cmd_i   | in  | valid/ready     | opcode, cmd_byte, volume_level
//   res_o   | out | valid/ready     | line_level, busy_res, status
//   apb     | in  | psel/penable    | paddr[3:0], pwdata/prdata 32 bits
//
// One beat per clock unless stalled: each command beat updates the sequencer state and
// lands in the result register at the same edge; its result is offered the next cycle.
// Throughput is set by the single result register, which refills in the cycle it drains.
// cmd_i.ready drops only while a result is held and res_o.ready is low.
// Reset is asynchronous, active low: line high, idle, registers at their defaults.
`include "one_wire_pulse_width_cmd_sender_assert.svh"

module one_wire_pulse_width_cmd_sender
  import owr_pkg::*;
#(
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  owr_cmd_if.sink           cmd_i,
  owr_res_if.source         res_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  cfg_t cfg;
  res_t res_d;
  res_t res_q;
  logic in_ready;
  logic accept;
  logic busy;

  assign accept      = cmd_i.valid & in_ready;
  assign cmd_i.ready = in_ready;

  owr_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  owr_fsm #(
    .COUNT_BITS (COUNT_BITS)
  ) u_fsm (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .opcode_i       (op_e'(cmd_i.opcode)),
    .cmd_byte_i     (cmd_i.cmd_byte),
    .volume_level_i (cmd_i.volume_level),
    .cfg_i          (cfg),
    .res_o          (res_d),
    .busy_o         (busy)
  );

  owr_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .res_i       (res_d),
    .out_ready_i (res_o.ready),
    .out_valid_o (res_o.valid),
    .res_o       (res_q),
    .in_ready_o  (in_ready)
  );

  assign res_o.line_level = res_q.line_level;
  assign res_o.busy_res   = res_q.busy_res;
  assign res_o.status     = res_q.status;

  // an accepted request from idle shows the line low and busy next cycle
  `OWR_ASSERT_NXT(a_req_starts_low, clk_i, rst_ni, accept && (cmd_i.opcode != OP_TICK) && !busy && !((cmd_i.opcode == OP_VOL) && (cmd_i.volume_level > VOL_MAX)), res_o.valid && !res_o.line_level && res_o.busy_res && (res_o.status == ST_OK))
  // input stalls only behind a held, untaken result
  `OWR_ASSERT_IMP(a_stall_cause, clk_i, rst_ni, !cmd_i.ready, res_o.valid && !res_o.ready)
  // the line is only low in the middle of a command
  `OWR_ASSERT_IMP(a_low_is_busy, clk_i, rst_ni, res_o.valid && !res_o.line_level, res_o.busy_res)
  // a busy reject never reports idle
  `OWR_ASSERT_IMP(a_reject_busy, clk_i, rst_ni, res_o.valid && (res_o.status == ST_BUSY), res_o.busy_res)

endmodule

FILE: dv/tb_one_wire_pulse_width_cmd_sender.sv
// Self-checking testbench for the one-wire command sender: directed table, then random traffic.
// Depends on owr_pkg, owr_ifs and the RTL top level; the line sequencer is predicted in-bench.
module tb_one_wire_pulse_width_cmd_sender;
  import owr_pkg::*;

  localparam int unsigned CNT_W = COUNT_BITS_DEF;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  logic clk_i;
  logic rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  owr_cmd_if cmd_if ();
  owr_res_if res_if ();

  one_wire_pulse_width_cmd_sender dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd_if),
    .res_o   (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Predicted sequencer state and timing registers
  phase_e           p_phase;
  logic [2:0]       p_bit;
  logic [7:0]       p_shift;
  logic [CNT_W-1:0] p_cnt;
  logic             p_line;
  cfg_t             p_cfg;

  res_t pending_line_q[$];

  bit src_idle;
  bit snk_idle;
  int err_cnt;
  int n_beats;
  int n_sent;
  int n_refused;
  int n_range;
  int n_settings;

  // Directed stimulus table
  typedef enum int {ROW_BEAT, ROW_TICKS, ROW_DRAIN, ROW_ZERO_CFG} row_kind_e;
  typedef struct {
    row_kind_e  kind;
    op_e        op;
    logic [7:0] cmd;
    logic [7:0] vol;
    int         reps;
    bit         typed;
    logic       line;
    logic       busy;
    status_e    st;
  } dir_row_t;

  localparam int N_DIR = 25;
  dir_row_t dir_tab [N_DIR] = '{
    // reset timing: idle tick, range errors, load, busy refusals
    '{ROW_BEAT,     OP_TICK, 8'h00, 8'h00,  0, 1'b1, 1'b1, 1'b0, ST_NONE},
    '{ROW_BEAT,     OP_VOL,  8'hFF, 8'h08,  0, 1'b1, 1'b1, 1'b0, ST_RANGE},
    '{ROW_BEAT,     OP_VOL,  8'h00, 8'hFF,  0, 1'b1, 1'b1, 1'b0, ST_RANGE},
    '{ROW_BEAT,     OP_RAW,  8'h00, 8'h00,  0, 1'b1, 1'b0, 1'b1, ST_OK},
    '{ROW_BEAT,     OP_RAW,  8'hFF, 8'h00,  0, 1'b1, 1'b0, 1'b1, ST_BUSY},
    // range check wins over busy
    '{ROW_BEAT,     OP_VOL,  8'h00, 8'h08,  0, 1'b1, 1'b0, 1'b1, ST_RANGE},
    '{ROW_BEAT,     OP_STOP, 8'h00, 8'h00,  0, 1'b1, 1'b0, 1'b1, ST_BUSY},
    '{ROW_BEAT,     OP_VOL,  8'h00, 8'h07,  0, 1'b1, 1'b0, 1'b1, ST_BUSY},
    '{ROW_TICKS,    OP_TICK, 8'h00, 8'h00, 39, 1'b0, 1'b0, 1'b0, ST_NONE},
    // 40th tick ends the default start time
    '{ROW_BEAT,     OP_TICK, 8'h00, 8'h00,  0, 1'b1, 1'b1, 1'b1, ST_NONE},
    // all-zero timing: every phase one tick, no guard
    '{ROW_ZERO_CFG, OP_TICK, 8'h00, 8'h00,  0, 1'b0, 1'b0, 1'b0, ST_NONE},
    '{ROW_DRAIN,    OP_TICK, 8'hFF, 8'hFF,  0, 1'b0, 1'b0, 1'b0, ST_NONE},
    '{ROW_BEAT,     OP_TICK, 8'hFF, 8'hFF,  0, 1'b1, 1'b1, 1'b0, ST_NONE},
    '{ROW_BEAT,     OP_STOP, 8'h00, 8'h00,  0, 1'b1, 1'b0, 1'b1, ST_OK},
    '{ROW_BEAT,     OP_TICK, 8'h00, 8'h00,  0, 1'b1, 1'b1, 1'b1, ST_NONE},
    '{ROW_BEAT,     OP_TICK, 8'h00, 8'h00,  0, 1'b1, 1'b0, 1'b1, ST_NONE},
    '{ROW_DRAIN,    OP_TICK, 8'h00, 8'h00,  0, 1'b0, 1'b0, 1'b0, ST_NONE},
    '{ROW_BEAT,     OP_VOL,  8'h00, 8'h00,  0, 1'b0, 1'b0, 1'b0, ST_NONE},
    '{ROW_DRAIN,    OP_TICK, 8'h00, 8'h00,  0, 1'b0, 1'b0, 1'b0, ST_NONE},
    '{ROW_BEAT,     OP_VOL,  8'h00, 8'h07,  0, 1'b0, 1'b0, 1'b0, ST_NONE},
    '{ROW_DRAIN,    OP_TICK, 8'h00, 8'h00,  0, 1'b0, 1'b0, 1'b0, ST_NONE},
    '{ROW_BEAT,     OP_RAW,  8'hFF, 8'h00,  0, 1'b0, 1'b0, 1'b0, ST_NONE},
    '{ROW_TICKS,    OP_TICK, 8'h00, 8'h00,  5, 1'b0, 1'b0, 1'b0, ST_NONE},
    '{ROW_BEAT,     OP_RAW,  8'h5A, 8'h00,  0, 1'b0, 1'b0, 1'b0, ST_NONE},
    '{ROW_DRAIN,    OP_TICK, 8'h00, 8'h00,  0, 1'b0, 1'b0, 1'b0, ST_NONE}
  };

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Phase of D ticks is over once the count reaches D (zero means one) or saturates
  function automatic bit span_done(logic [15:0] len);
    longint unsigned lim;
    lim = (len == '0) ? 1 : len;
    return (longint'(p_cnt) >= lim) || (p_cnt == CNT_MAX);
  endfunction

  // One tick of line time
  function automatic void line_tick();
    logic b;
    b = p_shift[0];
    if (p_phase == PH_IDLE) return;
    if (p_cnt != CNT_MAX) p_cnt = p_cnt + 1'b1;
    case (p_phase)
      PH_START: begin
        if (span_done(p_cfg.start_low_ticks)) begin
          p_phase = PH_HIGH; p_line = 1'b1; p_cnt = '0;
        end
      end
      PH_HIGH: begin
        if (span_done(b ? p_cfg.long_ticks : p_cfg.short_ticks)) begin
          p_phase = PH_LOW; p_line = 1'b0; p_cnt = '0;
        end
      end
      PH_LOW: begin
        if (span_done(b ? p_cfg.short_ticks : p_cfg.long_ticks)) begin
          p_line = 1'b1;
          p_cnt  = '0;
          if (p_bit == 3'd7) begin
            p_bit   = '0;
            p_phase = (p_cfg.guard_ticks == '0) ? PH_IDLE : PH_GUARD;
          end else begin
            p_bit   = p_bit + 1'b1;
            p_shift = p_shift >> 1;
            p_phase = PH_HIGH;
          end
        end
      end
      default: begin
        if (span_done(p_cfg.guard_ticks)) begin
          p_phase = PH_IDLE; p_cnt = '0;
        end
      end
    endcase
  endfunction

  function automatic status_e load_byte(logic [7:0] b);
    if (p_phase != PH_IDLE) return ST_BUSY;
    p_shift = b;
    p_bit   = '0;
    p_cnt   = '0;
    p_line  = 1'b0;
    p_phase = PH_START;
    return ST_OK;
  endfunction

  // Expected line result for one accepted command beat
  function automatic res_t predict_line(op_e op, logic [7:0] cmd, logic [7:0] vol);
    res_t    r;
    status_e st;
    st = ST_NONE;
    case (op)
      OP_TICK: line_tick();
      OP_RAW:  st = load_byte(cmd);
      OP_VOL:  st = (vol > VOL_MAX) ? ST_RANGE : load_byte(VOL_BASE + vol);
      default: st = load_byte(STOP_CODE);
    endcase
    r.line_level = p_line;
    r.busy_res   = (p_phase != PH_IDLE);
    r.status     = st;
    return r;
  endfunction

  // Drive one command beat; the expectation is queued at the accepting edge
  task automatic send_beat(op_e op, logic [7:0] cmd, logic [7:0] vol,
                           bit typed, res_t typed_res);
    int   gap;
    res_t r;
    gap = src_idle ? $urandom_range(0, 10) : 0;
    repeat (gap) begin
      cmd_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    cmd_if.valid        <= 1'b1;
    cmd_if.opcode       <= op;
    cmd_if.cmd_byte     <= cmd;
    cmd_if.volume_level <= vol;
    @(posedge clk_i);
    while (!cmd_if.ready) @(posedge clk_i);
    r = predict_line(op, cmd, vol);
    if (typed) r = typed_res;
    pending_line_q.push_back(r);
    n_beats++;
    case (r.status)
      ST_OK:    n_sent++;
      ST_BUSY:  n_refused++;
      ST_RANGE: n_range++;
      default: ;
    endcase
  endtask

  task automatic tick_to_idle();
    while (p_phase != PH_IDLE)
      send_beat(OP_TICK, 8'($urandom), 8'($urandom), 1'b0, '0);
  endtask

  // One APB transfer: setup cycle, then access cycle until pready
  task automatic apb_xfer(bit wr, logic [1:0] idx, logic [31:0] wdata,
                          output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
  endtask

  // Write and read back all timing registers once no result is pending
  task automatic set_timing(cfg_t c);
    logic [31:0] rd;
    logic [15:0] v;
    logic [15:0] junk;
    logic [1:0]  idx;
    cmd_if.valid <= 1'b0;
    wait (pending_line_q.size() == 0);
    repeat (4) @(posedge clk_i);
    for (int k = 0; k < 4; k++) begin
      idx  = k[1:0];
      junk = 16'($urandom);
      case (idx)
        REG_START: v = c.start_low_ticks;
        REG_LONG:  v = c.long_ticks;
        REG_SHORT: v = c.short_ticks;
        default:   v = c.guard_ticks;
      endcase
      apb_xfer(1'b1, idx, {junk, v}, rd);
      apb_xfer(1'b0, idx, '0, rd);
      if (rd[15:0] !== v) begin
        $error("register %0d readback: expected %0h, actual %0h", idx, v, rd[15:0]);
        err_cnt++;
      end
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    p_cfg = c;
    n_settings++;
  endtask

  // Random traffic: mostly whole commands, with refused and malformed requests mixed in
  task automatic run_random(int n_items);
    op_e        op;
    logic [7:0] cmd;
    logic [7:0] vol;
    bit         req;
    for (int i = 0; i < n_items; i++) begin
      if (i % 50 == 0) begin
        src_idle = ($urandom_range(0, 3) != 0);
        snk_idle = ($urandom_range(0, 3) != 0);
      end
      // hold the sender until every result is back
      if (i == n_items / 2) begin
        cmd_if.valid <= 1'b0;
        wait (pending_line_q.size() == 0);
        @(posedge clk_i);
      end
      if (p_phase == PH_IDLE) req = ($urandom_range(0, 9) < 7);
      else req = ($urandom_range(0, 99) < 12);
      cmd = 8'($urandom);
      if (req) begin
        op  = op_e'($urandom_range(1, 3));
        vol = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(8, 255))
                                          : 8'($urandom_range(0, 7));
      end else begin
        op  = OP_TICK;
        vol = 8'($urandom);
      end
      send_beat(op, cmd, vol, 1'b0, '0);
    end
    tick_to_idle();
  endtask

  // Result sink: random stall before each beat
  initial begin
    int gap;
    res_if.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      gap = snk_idle ? $urandom_range(0, 10) : 0;
      repeat (gap) begin
        res_if.ready <= 1'b0;
        @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!res_if.valid) @(posedge clk_i);
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    res_t e;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (pending_line_q.size() == 0) begin
        $error("result beat with no expectation pending");
        err_cnt++;
      end else begin
        e = pending_line_q.pop_front();
        if (res_if.line_level !== e.line_level) begin
          $error("line_level: expected %0d, actual %0d", e.line_level, res_if.line_level);
          err_cnt++;
        end
        if (res_if.busy_res !== e.busy_res) begin
          $error("busy_res: expected %0d, actual %0d", e.busy_res, res_if.busy_res);
          err_cnt++;
        end
        if (res_if.status !== e.status) begin
          $error("status: expected %0d, actual %0d", e.status, res_if.status);
          err_cnt++;
        end
      end
    end
  end

  // Run limit
  initial begin
    #1000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Main stimulus
  initial begin
    dir_row_t row;
    res_t     tr;
    cfg_t     c;
    rst_ni              <= 1'b0;
    cmd_if.valid        <= 1'b0;
    cmd_if.opcode       <= OP_TICK;
    cmd_if.cmd_byte     <= '0;
    cmd_if.volume_level <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    src_idle = 1'b1;
    snk_idle = 1'b1;
    p_phase = PH_IDLE;
    p_bit   = '0;
    p_shift = '0;
    p_cnt   = '0;
    p_line  = 1'b1;
    p_cfg.start_low_ticks = START_RST;
    p_cfg.long_ticks      = LONG_RST;
    p_cfg.short_ticks     = SHORT_RST;
    p_cfg.guard_ticks     = GUARD_RST;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    for (int i = 0; i < N_DIR; i++) begin
      row = dir_tab[i];
      tr.line_level = row.line;
      tr.busy_res   = row.busy;
      tr.status     = row.st;
      case (row.kind)
        ROW_BEAT:  send_beat(row.op, row.cmd, row.vol, row.typed, tr);
        ROW_TICKS: begin
          repeat (row.reps) send_beat(OP_TICK, row.cmd, row.vol, 1'b0, '0);
        end
        ROW_DRAIN: tick_to_idle();
        default: begin
          c = '0;
          set_timing(c);
        end
      endcase
    end

    // random timing settings with short durations
    for (int s = 0; s < 8; s++) begin
      c.start_low_ticks = 16'($urandom_range(0, 8));
      c.long_ticks      = 16'($urandom_range(0, 6));
      c.short_ticks     = 16'($urandom_range(0, 6));
      c.guard_ticks     = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(1, 30));
      set_timing(c);
      run_random(70);
    end

    // largest timing values, written and read back only
    c.start_low_ticks = 16'hFFFF;
    c.long_ticks      = 16'hFFFF;
    c.short_ticks     = 16'hFFFF;
    c.guard_ticks     = 16'hFFFF;
    set_timing(c);

    // a last stretch of random traffic with small timing
    src_idle = 1'b1;
    snk_idle = 1'b1;
    c.start_low_ticks = 16'd2;
    c.long_ticks      = 16'd3;
    c.short_ticks     = 16'd1;
    c.guard_ticks     = 16'd5;
    set_timing(c);
    run_random(80);

    // drain and report
    cmd_if.valid <= 1'b0;
    wait (pending_line_q.size() == 0);
    repeat (8) @(posedge clk_i);
    $display("Checked %0d command beats across %0d timing settings.", n_beats, n_settings);
    $display("Requests: %0d loaded, %0d refused while busy, %0d volume out of range.",
             n_sent, n_refused, n_range);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
